// ===== hw/rtl/polar_mood_sector_classifier_unit_defines.svh =====
// Assertion macros for the polar mood sector classifier
`ifndef POLAR_MOOD_SECTOR_CLASSIFIER_UNIT_DEFINES_SVH
`define POLAR_MOOD_SECTOR_CLASSIFIER_UNIT_DEFINES_SVH

// same-cycle implication
`define PMSC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication after a fixed number of cycles
`define PMSC_ASSERT_AFTER(label, clk, rst_n, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/pmsc_pkg.sv =====
package pmsc_pkg;

    localparam int NUM_BOUNDS = 20;
    localparam int NUM_THR    = 4;

    typedef logic signed [17:0] t_coef;
    typedef logic [4:0]         t_sector;

    typedef enum logic [2:0] {
        LVL_NEUTRAL    = 3'd0,
        LVL_SLIGHTLY   = 3'd1,
        LVL_MODERATELY = 3'd2,
        LVL_VERY       = 3'd3,
        LVL_EXTREMELY  = 3'd4
    } t_level;

    localparam t_sector SEC_PLEASED   = 5'd0;
    localparam t_sector SEC_AROUSED   = 5'd5;
    localparam t_sector SEC_DEPRESSED = 5'd15;
    localparam t_sector SEC_SLEEPY    = 5'd19;

    // cos/sin of 16,34,...,340,354 deg, scaled by 65536
    localparam t_coef BOUND_COS [NUM_BOUNDS] = '{
        18'sd62997, 18'sd54332, 18'sd40348, 18'sd22415, 18'sd2287,
        -18'sd18064, -18'sd36647, -18'sd51643, -18'sd61584, -18'sd65496,
        -18'sd62997, -18'sd54332, -18'sd40348, -18'sd22415, -18'sd2287,
        18'sd18064, 18'sd36647, 18'sd51643, 18'sd61584, 18'sd65177
    };
    localparam t_coef BOUND_SIN [NUM_BOUNDS] = '{
        18'sd18064, 18'sd36647, 18'sd51643, 18'sd61584, 18'sd65496,
        18'sd62997, 18'sd54332, 18'sd40348, 18'sd22415, 18'sd2287,
        -18'sd18064, -18'sd36647, -18'sd51643, -18'sd61584, -18'sd65496,
        -18'sd62997, -18'sd54332, -18'sd40348, -18'sd22415, -18'sd6850
    };

    // level thresholds in Q2.14 and their squares
    localparam logic [14:0] THR    [NUM_THR] = '{15'd1639, 15'd5325, 15'd9012, 15'd12698};
    localparam logic [27:0] THR_SQ [NUM_THR] = '{
        28'd2686321, 28'd28355625, 28'd81216144, 28'd161239204
    };

endpackage

// ===== hw/rtl/pmsc_sector.sv =====
module pmsc_sector
    import pmsc_pkg::*;
(
    input  logic               i_clk,
    input  logic signed [15:0] i_arousal,
    input  logic signed [15:0] i_valence,
    output t_sector            o_sector
);

    // stage 1: boundary products
    logic signed [33:0] r_pc [NUM_BOUNDS];
    logic signed [33:0] r_ps [NUM_BOUNDS];
    logic signed [33:0] n_pc [NUM_BOUNDS];
    logic signed [33:0] n_ps [NUM_BOUNDS];
    logic               r_upper1, r_xzero1, r_yneg1;

    always_comb begin
        for (int k = 0; k < NUM_BOUNDS; k++) begin
            n_pc[k] = 34'(BOUND_COS[k]) * 34'(i_arousal);
            n_ps[k] = 34'(BOUND_SIN[k]) * 34'(i_valence);
        end
    end

    always_ff @(posedge i_clk) begin
        r_pc     <= n_pc;
        r_ps     <= n_ps;
        r_upper1 <= (i_arousal > 16'sd0) || (i_arousal == 16'sd0 && i_valence > 16'sd0);
        r_xzero1 <= (i_valence == 16'sd0);
        r_yneg1  <= i_arousal[15];
    end

    // stage 2: cross product signs
    logic [NUM_BOUNDS-2:0] r_ge, n_ge;
    logic                  r_gt_last, n_gt_last;
    logic signed [34:0]    diff [NUM_BOUNDS];
    logic                  r_upper2, r_xzero2, r_yneg2;

    always_comb begin
        for (int k = 0; k < NUM_BOUNDS; k++) begin
            diff[k] = 35'(r_pc[k]) - 35'(r_ps[k]);
        end
        for (int k = 0; k < NUM_BOUNDS - 1; k++) begin
            n_ge[k] = !diff[k][34];
        end
        n_gt_last = !diff[NUM_BOUNDS-1][34] && (diff[NUM_BOUNDS-1] != 35'sd0);
    end

    always_ff @(posedge i_clk) begin
        r_ge      <= n_ge;
        r_gt_last <= n_gt_last;
        r_upper2  <= r_upper1;
        r_xzero2  <= r_xzero1;
        r_yneg2   <= r_yneg1;
    end

    // stage 3: sector count
    t_sector r_sector, n_sector;
    t_sector cnt;

    always_comb begin
        cnt = '0;
        if (r_upper2) begin
            for (int k = 0; k < NUM_BOUNDS / 2; k++) begin
                cnt = cnt + t_sector'(r_ge[k]);
            end
        end else begin
            cnt = t_sector'(NUM_BOUNDS / 2);
            for (int k = NUM_BOUNDS / 2; k < NUM_BOUNDS - 1; k++) begin
                cnt = cnt + t_sector'(r_ge[k]);
            end
        end
        if (r_xzero2) begin
            n_sector = r_yneg2 ? SEC_DEPRESSED : SEC_AROUSED;
        end else if (cnt == '0 || (!r_upper2 && r_gt_last)) begin
            n_sector = SEC_PLEASED;
        end else begin
            n_sector = cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sector <= n_sector;
    end

    assign o_sector = r_sector;

endmodule

// ===== hw/rtl/polar_mood_sector_classifier_unit.sv =====
// Polar mood sector classifier. Takes one item per clock (start) and gives its result,
// strobed by o_valid for one cycle, once it has passed the three register stages of the
// pipeline (products, compares, sector count). The pipeline never stalls, so busy is
// high only while reset is held.
// The receiver cannot hold results off and must take each one when o_valid is high.
`include "polar_mood_sector_classifier_unit_defines.svh"

module polar_mood_sector_classifier_unit
    import pmsc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_arousal,
    input  logic signed [15:0] i_valence,
    input  logic signed [15:0] i_intensity,
    output logic               o_valid,
    output logic [2:0]         o_intensity_level,
    output logic [4:0]         o_emotion_sector
);

    logic [2:0] r_vld;
    logic       xfer;

    assign busy = !i_rst_n;
    assign xfer = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], xfer};
        end
    end

    // stage 1: squares
    logic [31:0] r_aa, r_vv;
    logic [14:0] r_imag;
    logic        r_ineg;

    always_ff @(posedge i_clk) begin
        r_aa   <= 32'(i_arousal * i_arousal);
        r_vv   <= 32'(i_valence * i_valence);
        r_imag <= i_intensity[14:0];
        r_ineg <= i_intensity[15];
    end

    // stage 2: level
    logic [32:0] sumsq;
    t_level      n_level, r_level2, r_level3;

    always_comb begin
        sumsq   = {1'b0, r_aa} + {1'b0, r_vv};
        n_level = LVL_NEUTRAL;
        for (int k = 0; k < NUM_THR; k++) begin
            if (r_ineg ? (sumsq >= {5'd0, THR_SQ[k]}) : (r_imag >= THR[k])) begin
                n_level = t_level'(k + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_level2 <= n_level;
        r_level3 <= r_level2;
    end

    t_sector sector;

    pmsc_sector u_sector (
        .i_clk     (i_clk),
        .i_arousal (i_arousal),
        .i_valence (i_valence),
        .o_sector  (sector)
    );

    assign o_valid           = r_vld[2];
    assign o_intensity_level = r_level3;
    assign o_emotion_sector  = (r_level3 == LVL_NEUTRAL) ? SEC_PLEASED : sector;

    `PMSC_ASSERT_AFTER(a_latency, i_clk, i_rst_n, xfer, 3, o_valid, "result strobe missing")
    `PMSC_ASSERT_NOW(a_level_rng, i_clk, i_rst_n, o_valid,
        o_intensity_level <= LVL_EXTREMELY, "level out of range")
    `PMSC_ASSERT_NOW(a_sector_rng, i_clk, i_rst_n, o_valid,
        o_emotion_sector <= SEC_SLEEPY, "sector out of range")
    `PMSC_ASSERT_NOW(a_neutral, i_clk, i_rst_n, o_valid && o_intensity_level == LVL_NEUTRAL,
        o_emotion_sector == SEC_PLEASED, "neutral with sector")

endmodule
